// ===== rtl/urtb_pkg.sv =====
// shared types and constants for the uart receive/transmit ring buffers
package urtb_pkg;

  localparam int RX_DEPTH_DEF = 32;
  localparam int TX_DEPTH_DEF = 32;
  localparam int BYTE_W       = 8;
  localparam int CMD_W        = 2;
  localparam int FLAG_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_GET      = 2'd2,
    CMD_PUT      = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic step;
  } ctrl_cmd_t;

  // result flags, highest bit first in the packed order below (out_valid is bit 0)
  typedef struct packed {
    logic tx_irq_enabled;
    logic put_rejected;
    logic overflow_error;
    logic no_data;
    logic out_valid;
  } flags_t;

endpackage

// ===== rtl/uart_rx_tx_ring_buffers.sv =====
// top level of the uart receive and transmit ring buffers
//
// input stream: one event per transfer. s_tuser carries the event kind
// (line byte received, transmitter ready, software get, software put),
// s_tdata the byte for receive and put.
// output stream: one result per event. m_tdata is the byte read by get or
// the byte to send on transmitter ready (zero when none); m_tuser holds the
// status flags.
// each buffer keeps DEPTH-1 bytes at most; head and tail pointers advance
// before each access. stores sit in two small rams with registered reads.
// the result is offered in the cycle after the input transfer, once the ram
// read has landed. the accept/respond controller takes no new event until
// the pending result has been transferred.
// a stalled output (m_tready low) holds the result and keeps s_tready low.
// reset empties both buffers and clears the overflow flag and the transmit
// interrupt enable; store contents are not cleared.
module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [1:0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [4:0] m_tuser    // [0] out_valid, [1] no_data, [2] overflow_error,
                                // [3] put_rejected, [4] tx_irq_enabled
);

  urtb_pkg::ctrl_cmd_t ctrl_cmd;
  urtb_pkg::flags_t    flags;

  urtb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (ctrl_cmd)
  );

  urtb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .ev        (s_tuser),
    .data_byte (s_tdata),
    .out_byte  (m_tdata),
    .flags     (flags)
  );

  assign m_tuser = flags;

endmodule

// ===== rtl/urtb_ram.sv =====
// generic single write port ram with a registered read port
module urtb_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/urtb_ctrl.sv =====
// handshake controller: takes one event, then holds its result until taken
module urtb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output urtb_pkg::ctrl_cmd_t cmd
);

  urtb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urtb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      urtb_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = urtb_pkg::ST_RESP;
      end
      urtb_pkg::ST_RESP: begin
        if (m_tready) state_next = urtb_pkg::ST_IDLE;
      end
      default: state_next = urtb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    cmd.step = 1'b0;
    unique case (state)
      urtb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.step = s_tvalid;
      end
      urtb_pkg::ST_RESP: begin
        m_tvalid = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/urtb_dp.sv =====
// pointers, flags and the two byte stores
module urtb_dp #(
  parameter int RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  urtb_pkg::ctrl_cmd_t           cmd,
  input  logic [urtb_pkg::CMD_W-1:0]    ev,
  input  logic [urtb_pkg::BYTE_W-1:0]   data_byte,
  output logic [urtb_pkg::BYTE_W-1:0]   out_byte,
  output urtb_pkg::flags_t              flags
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  logic [RX_AW-1:0] rx_head, rx_tail, rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head, tx_tail, tx_head_inc, tx_tail_inc;
  logic sticky_overflow, tx_irq_on;
  logic res_valid, res_nodata, res_oerr, res_rej, res_from_tx;

  logic rx_full, rx_empty, tx_full, tx_empty;
  logic rx_we, rx_re, tx_we, tx_re;
  logic [urtb_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;
  urtb_pkg::cmd_t ev_code;

  assign ev_code = urtb_pkg::cmd_t'(ev);

  assign rx_head_inc = (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + RX_AW'(1);
  assign rx_tail_inc = (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + RX_AW'(1);
  assign tx_head_inc = (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + TX_AW'(1);
  assign tx_tail_inc = (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + TX_AW'(1);

  // one slot stays free, so full is head+1 == tail
  assign rx_full  = (rx_head_inc == rx_tail);
  assign rx_empty = (rx_head == rx_tail);
  assign tx_full  = (tx_head_inc == tx_tail);
  assign tx_empty = (tx_head == tx_tail);

  assign rx_we = cmd.step && (ev_code == urtb_pkg::CMD_RX_BYTE) && !rx_full;
  assign rx_re = cmd.step && (ev_code == urtb_pkg::CMD_GET) && !rx_empty;
  assign tx_we = cmd.step && (ev_code == urtb_pkg::CMD_PUT) && !tx_full;
  assign tx_re = cmd.step && (ev_code == urtb_pkg::CMD_TX_READY) && !tx_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head         <= '0;
      rx_tail         <= '0;
      tx_head         <= '0;
      tx_tail         <= '0;
      sticky_overflow <= 1'b0;
      tx_irq_on       <= 1'b0;
    end else if (cmd.step) begin
      case (ev_code)
        urtb_pkg::CMD_RX_BYTE: begin
          if (rx_full) sticky_overflow <= 1'b1;
          else rx_head <= rx_head_inc;
        end
        urtb_pkg::CMD_TX_READY: begin
          if (tx_empty) tx_irq_on <= 1'b0;
          else tx_tail <= tx_tail_inc;
        end
        urtb_pkg::CMD_GET: begin
          if (!rx_empty) begin
            rx_tail         <= rx_tail_inc;
            sticky_overflow <= 1'b0;
          end
        end
        default: begin
          if (!tx_full) begin
            tx_head   <= tx_head_inc;
            tx_irq_on <= 1'b1;
          end
        end
      endcase
    end
  end

  // result flags captured with the event
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res_valid   <= rx_re || tx_re;
      res_from_tx <= (ev_code == urtb_pkg::CMD_TX_READY);
      res_nodata  <= (ev_code == urtb_pkg::CMD_GET) && rx_empty;
      res_oerr    <= ((ev_code == urtb_pkg::CMD_RX_BYTE) && rx_full) ||
                     ((ev_code == urtb_pkg::CMD_GET) && !rx_empty && sticky_overflow);
      res_rej     <= (ev_code == urtb_pkg::CMD_PUT) && tx_full;
    end
  end

  urtb_ram #(
    .WIDTH (urtb_pkg::BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_inc),
    .wdata (data_byte),
    .re    (rx_re),
    .raddr (rx_tail_inc),
    .rdata (rx_rdata)
  );

  urtb_ram #(
    .WIDTH (urtb_pkg::BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_inc),
    .wdata (data_byte),
    .re    (tx_re),
    .raddr (tx_tail_inc),
    .rdata (tx_rdata)
  );

  // read data holds until the next read, which only comes with the next event
  always_comb begin
    if (!res_valid) out_byte = '0;
    else if (res_from_tx) out_byte = tx_rdata;
    else out_byte = rx_rdata;
  end

  assign flags.out_valid      = res_valid;
  assign flags.no_data        = res_nodata;
  assign flags.overflow_error = res_oerr;
  assign flags.put_rejected   = res_rej;
  assign flags.tx_irq_enabled = tx_irq_on;

endmodule
